[rtl/irz_pkg.sv]
// Shared types, constants and helpers for the four-zone watering timer.
package irz_pkg;

   // Number of zones that are actually built (1..4); the result masks stay 4 bits wide
   localparam int ZONE_COUNT = 4;
   localparam int MASK_W     = 4;
   localparam int SCHED_W    = 22;
   localparam int SECS_W     = 16;
   localparam int DUR_W      = 10;
   localparam int LAST_MIN_W = 7;

   // Schedule register fields
   localparam int SCHED_EN_BIT = 0;
   localparam int SCHED_HR_LO  = 1;
   localparam int SCHED_HR_HI  = 5;
   localparam int SCHED_MN_LO  = 6;
   localparam int SCHED_MN_HI  = 11;
   localparam int SCHED_DU_LO  = 12;
   localparam int SCHED_DU_HI  = 21;

   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINUTE_MAX = 6'd59;
   localparam logic [7:0] MANUAL_MIN = 8'd1;
   localparam logic [7:0] MANUAL_MAX = 8'd120;
   localparam logic [LAST_MIN_W-1:0] NO_MINUTE = 7'd127;

   // Schedule values after reset, zone one first
   localparam logic [SCHED_W-1:0] SCHED_RESET [MASK_W] = '{
      22'd42892, 22'd40974, 22'd61476, 22'd61478
   };

   typedef enum logic [1:0] {
      FUNC_TICK     = 2'd0,
      FUNC_START    = 2'd1,
      FUNC_STOP     = 2'd2,
      FUNC_STOP_ALL = 2'd3
   } func_type;

   // Command broadcast to every zone for one transfer
   typedef struct packed {
      logic              fire;
      func_type          func;
      logic [1:0]        zone;
      logic              scan;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [SECS_W-1:0] manual_secs;
   } zone_cmd_type;

   // What one zone reports back for the current transfer
   typedef struct packed {
      logic active_next;
      logic started;
      logic stopped;
   } zone_status_type;

   // Minutes to seconds: m * 60 as (m << 6) - (m << 2)
   function automatic logic [SECS_W-1:0] secs_of_minutes(input logic [DUR_W-1:0] m);
      logic [SECS_W-1:0] w;
      w = SECS_W'(m);
      return (w << 6) - (w << 2);
   endfunction

endpackage

[rtl/irz_zone.sv]
// One watering zone: relay state, countdown and schedule match.
module irz_zone (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     zone_id,
   input  logic [irz_pkg::SCHED_W-1:0]    sched,
   input  irz_pkg::zone_cmd_type          cmd,
   output irz_pkg::zone_status_type       status
);
   import irz_pkg::*;

   logic              active_ff, active_in;
   logic [SECS_W-1:0] secs_ff, secs_in;

   logic              sel;
   logic [SECS_W-1:0] secs_dec;
   logic              expire;
   logic              still_on;
   logic [4:0]        sch_hour;
   logic [5:0]        sch_min;
   logic              match;
   logic              started;
   logic              stopped;

   assign sel      = (cmd.zone == zone_id);
   assign sch_hour = sched[SCHED_HR_HI:SCHED_HR_LO];
   assign sch_min  = sched[SCHED_MN_HI:SCHED_MN_LO];

   // Countdown saturates at zero; a running zone that reaches zero switches off
   assign secs_dec = (secs_ff != '0) ? secs_ff - SECS_W'(1) : secs_ff;
   assign expire   = active_ff && (secs_dec == '0);
   assign still_on = active_ff && !expire;

   // Out-of-range schedule times never match
   assign match = sched[SCHED_EN_BIT] && (sch_hour <= HOUR_MAX) && (sch_min <= MINUTE_MAX)
                  && (sch_hour == cmd.hour) && (sch_min == cmd.minute);

   // Next state for this transfer
   always_comb begin
      active_in = active_ff;
      secs_in   = secs_ff;
      started   = 1'b0;
      stopped   = 1'b0;
      unique case (cmd.func)
         FUNC_TICK: begin
            if (active_ff) begin
               active_in = still_on;
               secs_in   = secs_dec;
            end
            stopped = expire;
            if (cmd.scan && match && !still_on) begin
               active_in = 1'b1;
               secs_in   = secs_of_minutes(sched[SCHED_DU_HI:SCHED_DU_LO]);
               started   = 1'b1;
            end
         end
         FUNC_START: begin
            if (sel) begin
               active_in = 1'b1;
               secs_in   = cmd.manual_secs;
               started   = 1'b1;
            end
         end
         FUNC_STOP: begin
            if (sel) begin
               stopped   = active_ff;
               active_in = 1'b0;
               secs_in   = '0;
            end
         end
         FUNC_STOP_ALL: begin
            stopped   = active_ff;
            active_in = 1'b0;
            secs_in   = '0;
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         secs_ff   <= '0;
      end else if (cmd.fire) begin
         active_ff <= active_in;
         secs_ff   <= secs_in;
      end
   end

   assign status.active_next = active_in;
   assign status.started     = started;
   assign status.stopped     = stopped;

endmodule

[rtl/irrigation_zone_timer.sv]
// Top level of the four-zone watering timer: input stage, zones and result register.
// Every transfer on req_ (tick, manual start, manual stop, stop all) gives exactly one
// transfer on rsp_ with the relay mask after the item and the masks of zones started
// and stopped by it. An item passes the input register and then the result register before
// rsp_valid rises. One item can be taken every cycle while rsp_ready stays high, since all
// per-item work is one shallow combinational pass from the input register to the result
// register; while a result waits, a full input register holds its item and req_ready
// stays low. A tick counts down running zones (one second per tick), then, if time_valid
// is high and the minute differs from the last one seen, starts enabled idle zones whose
// schedule matches. The user must write schedules through csr_ (index 0..3 for zones one
// to four) only while the block is idle; the block itself does not enforce this.
module irrigation_zone_timer (
   input  logic                          clock,
   input  logic                          reset,
   // Input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [1:0]                    req_zone,
   input  logic [7:0]                    req_minutes,
   input  logic [4:0]                    req_hour,
   input  logic [5:0]                    req_minute,
   input  logic                          req_time_valid,
   // Results
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [3:0]                    rsp_relay_mask,
   output logic [3:0]                    rsp_started_mask,
   output logic [3:0]                    rsp_stopped_mask,
   // Schedule registers
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [irz_pkg::SCHED_W-1:0]   csr_wdata
);
   import irz_pkg::*;

   // Input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_func_ff;
   logic [1:0]            s1_zone_ff;
   logic [7:0]            s1_minutes_ff;
   logic [4:0]            s1_hour_ff;
   logic [5:0]            s1_minute_ff;
   logic                  s1_tvalid_ff;

   // Result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]     relay_ff, started_ff, stopped_ff;

   logic [LAST_MIN_W-1:0] last_min_ff, last_min_in;
   logic [SCHED_W-1:0]    sched_ff [ZONE_COUNT];

   logic                  fire;
   logic                  scan;
   logic [7:0]            mins_clamped;
   zone_cmd_type          cmd;
   zone_status_type       status [MASK_W];
   logic [MASK_W-1:0]     relay_next, started_next, stopped_next;

   // The input stage moves on when the result register is free or being drained
   assign fire        = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || fire;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_func_ff    <= req_func;
         s1_zone_ff    <= req_zone;
         s1_minutes_ff <= req_minutes;
         s1_hour_ff    <= req_hour;
         s1_minute_ff  <= req_minute;
         s1_tvalid_ff  <= req_time_valid;
      end
   end

   // Minute dedupe: only the minute is compared
   assign scan = (func_type'(s1_func_ff) == FUNC_TICK) && s1_tvalid_ff
                 && (LAST_MIN_W'(s1_minute_ff) != last_min_ff);
   assign last_min_in = (fire && scan) ? LAST_MIN_W'(s1_minute_ff) : last_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_min_ff <= NO_MINUTE;
      end else begin
         last_min_ff <= last_min_in;
      end
   end

   // Manual run length clamped to 1..120 minutes
   always_comb begin
      priority if (s1_minutes_ff < MANUAL_MIN) begin
         mins_clamped = MANUAL_MIN;
      end else if (s1_minutes_ff > MANUAL_MAX) begin
         mins_clamped = MANUAL_MAX;
      end else begin
         mins_clamped = s1_minutes_ff;
      end
   end

   assign cmd.fire        = fire;
   assign cmd.func        = func_type'(s1_func_ff);
   assign cmd.zone        = s1_zone_ff;
   assign cmd.scan        = scan;
   assign cmd.hour        = s1_hour_ff;
   assign cmd.minute      = s1_minute_ff;
   assign cmd.manual_secs = secs_of_minutes(DUR_W'(mins_clamped));

   // Zones; mask bits above the zone count stay low
   for (genvar z = 0; z < MASK_W; z++) begin : g_zone
      if (z < ZONE_COUNT) begin : g_on
         always_ff @(posedge clock) begin
            if (reset) begin
               sched_ff[z] <= SCHED_RESET[z];
            end else if (csr_we && (csr_index == 2'(z))) begin
               sched_ff[z] <= csr_wdata;
            end
         end

         irz_zone u_zone (
            .clock   (clock),
            .reset   (reset),
            .zone_id (2'(z)),
            .sched   (sched_ff[z]),
            .cmd     (cmd),
            .status  (status[z])
         );
      end else begin : g_off
         assign status[z] = '0;
      end
      assign relay_next[z]   = status[z].active_next;
      assign started_next[z] = status[z].started;
      assign stopped_next[z] = status[z].stopped;
   end

   // Result register
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         relay_ff   <= relay_next;
         started_ff <= started_next;
         stopped_ff <= stopped_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_relay_mask   = relay_ff;
   assign rsp_started_mask = started_ff;
   assign rsp_stopped_mask = stopped_ff;

`ifndef SYNTHESIS
   // A started zone is always on in the same result
   a_started_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((started_ff & ~relay_ff) == '0))
      else $error("started zone not on");

   // A zone stopped and not restarted is off
   a_stopped_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((stopped_ff & ~started_ff & relay_ff) == '0))
      else $error("stopped zone still on");

   // Every processed item leaves a result behind
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed item gave no result");

   // A scanned tick records its minute
   a_dedupe_record: assert property (@(posedge clock) disable iff (reset)
      (fire && scan) |=> (last_min_ff == LAST_MIN_W'($past(s1_minute_ff))))
      else $error("minute not recorded");
`endif

endmodule

[tb/tb.sv]
// Testbench for the four-zone watering timer: directed plan, random traffic, self-checking.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import irz_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYC    = 5;
   localparam int SETTLE_CYC   = 6;
   localparam int HOLDOFF_CYC  = 250;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 195;
   localparam int CYCLE_LIMIT  = 300000;
   localparam logic [SECS_W-1:0] SECS_PER_MIN = 16'd60;

   // Schedule register indexes
   localparam logic [1:0] ZONE1_SCHED = 2'd0;
   localparam logic [1:0] ZONE2_SCHED = 2'd1;
   localparam logic [1:0] ZONE3_SCHED = 2'd2;
   localparam logic [1:0] ZONE4_SCHED = 2'd3;

   // Kinds of schedule setting used by the random phases
   localparam int SET_ALL_ZERO  = 0;
   localparam int SET_ALL_ONES  = 1;
   localparam int SET_RESET     = 2;
   localparam int SET_WIDE      = 3;
   localparam int SET_SHORT     = 4;

   typedef struct packed {
      logic [3:0] relay;
      logic [3:0] started;
      logic [3:0] stopped;
   } zone_masks_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      func_type          func;
      logic [1:0]        zone;
      logic [7:0]        minutes;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic              time_valid;
      logic [1:0]        reg_idx;
      logic [SCHED_W-1:0] value;
      bit                typed;
      zone_masks_type    want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_func = 2'd0;
   logic [1:0] req_zone = 2'd0;
   logic [7:0] req_minutes = 8'd0;
   logic [4:0] req_hour = 5'd0;
   logic [5:0] req_minute = 6'd0;
   logic req_time_valid = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_relay_mask;
   logic [3:0] rsp_started_mask;
   logic [3:0] rsp_stopped_mask;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [SCHED_W-1:0] csr_wdata = '0;

   // Timer state as the testbench sees it
   logic [MASK_W-1:0]     zone_on;
   logic [SECS_W-1:0]     secs_left [MASK_W];
   logic [LAST_MIN_W-1:0] last_min;
   logic [SCHED_W-1:0]    sched_reg [MASK_W];

   zone_masks_type expected_masks [$];
   plan_row_type   plan [$];

   logic [4:0] cur_hour = 5'd0;
   logic [5:0] cur_min  = 6'd0;
   int  errors = 0;
   int  items_sent = 0;
   int  directed_items = 0;
   int  rsp_checked = 0;
   int  starts_seen = 0;
   int  stops_seen = 0;
   int  settings_loaded = 0;
   int  holdoffs = 0;
   int  cycle_count = 0;
   bit  holdoff_req = 1'b0;

   irrigation_zone_timer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_zone         (req_zone),
      .req_minutes      (req_minutes),
      .req_hour         (req_hour),
      .req_minute       (req_minute),
      .req_time_valid   (req_time_valid),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_relay_mask   (rsp_relay_mask),
      .rsp_started_mask (rsp_started_mask),
      .rsp_stopped_mask (rsp_stopped_mask),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one item to the timer state and return the masks it yields
   function automatic zone_masks_type advance_timer(func_type f, logic [1:0] zn,
                                                    logic [7:0] mins, logic [4:0] hr,
                                                    logic [5:0] mn, logic tv);
      zone_masks_type r;
      logic [7:0] m;
      logic [4:0] sh;
      logic [5:0] sm;
      logic [DUR_W-1:0] sd;
      int z;
      r = '0;
      case (f)
         FUNC_TICK: begin
            // countdown first, then the schedule scan for a fresh minute
            for (z = 0; z < ZONE_COUNT; z++) begin
               if (zone_on[z]) begin
                  if (secs_left[z] != '0) secs_left[z] = secs_left[z] - 1'b1;
                  if (secs_left[z] == '0) begin
                     zone_on[z] = 1'b0;
                     r.stopped[z] = 1'b1;
                  end
               end
            end
            if (tv && {1'b0, mn} != last_min) begin
               last_min = {1'b0, mn};
               for (z = 0; z < ZONE_COUNT; z++) begin
                  sh = sched_reg[z][SCHED_HR_HI:SCHED_HR_LO];
                  sm = sched_reg[z][SCHED_MN_HI:SCHED_MN_LO];
                  sd = sched_reg[z][SCHED_DU_HI:SCHED_DU_LO];
                  if (sched_reg[z][SCHED_EN_BIT] && sh <= HOUR_MAX && sm <= MINUTE_MAX &&
                      sh == hr && sm == mn && !zone_on[z]) begin
                     zone_on[z] = 1'b1;
                     secs_left[z] = SECS_W'(sd) * SECS_PER_MIN;
                     r.started[z] = 1'b1;
                  end
               end
            end
         end
         FUNC_START: begin
            if (zn < ZONE_COUNT) begin
               m = mins;
               if (m < MANUAL_MIN) m = MANUAL_MIN;
               if (m > MANUAL_MAX) m = MANUAL_MAX;
               zone_on[zn] = 1'b1;
               secs_left[zn] = SECS_W'(m) * SECS_PER_MIN;
               r.started[zn] = 1'b1;
            end
         end
         FUNC_STOP: begin
            if (zn < ZONE_COUNT) begin
               r.stopped[zn] = zone_on[zn];
               zone_on[zn] = 1'b0;
               secs_left[zn] = '0;
            end
         end
         default: begin
            for (z = 0; z < ZONE_COUNT; z++) begin
               r.stopped[z] = zone_on[z];
               zone_on[z] = 1'b0;
               secs_left[z] = '0;
            end
         end
      endcase
      r.relay = zone_on;
      return r;
   endfunction

   function automatic logic [SCHED_W-1:0] pack_sched(logic en, logic [4:0] hr,
                                                     logic [5:0] mn, logic [DUR_W-1:0] dur);
      return {dur, mn, hr, en};
   endfunction

   function automatic plan_row_type item_row(func_type f, logic [1:0] zn, logic [7:0] mins,
                                             logic [4:0] hr, logic [5:0] mn, logic tv,
                                             bit typed, logic [3:0] relay,
                                             logic [3:0] started, logic [3:0] stopped);
      plan_row_type r;
      r.kind = ROW_ITEM;
      r.func = f;
      r.zone = zn;
      r.minutes = mins;
      r.hour = hr;
      r.minute = mn;
      r.time_valid = tv;
      r.reg_idx = ZONE1_SCHED;
      r.value = '0;
      r.typed = typed;
      r.want = {relay, started, stopped};
      return r;
   endfunction

   function automatic plan_row_type csr_row(logic [1:0] idx, logic [SCHED_W-1:0] v);
      plan_row_type r;
      r = item_row(FUNC_TICK, 2'd0, 8'd0, 5'd0, 6'd0, 1'b0, 1'b0, 4'h0, 4'h0, 4'h0);
      r.kind = ROW_CSR;
      r.reg_idx = idx;
      r.value = v;
      return r;
   endfunction

   // Offer one item, hold it until the transfer, then log what it should give
   task automatic offer_item(func_type f, logic [1:0] zn, logic [7:0] mins, logic [4:0] hr,
                             logic [5:0] mn, logic tv, bit typed, zone_masks_type want);
      zone_masks_type r;
      req_valid <= 1'b1;
      req_func <= f;
      req_zone <= zn;
      req_minutes <= mins;
      req_hour <= hr;
      req_minute <= mn;
      req_time_valid <= tv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = advance_timer(f, zn, mins, hr, mn, tv);
      if (typed) r = want;
      starts_seen += $countones(r.started);
      stops_seen += $countones(r.stopped);
      expected_masks.push_back(r);
      items_sent++;
   endtask

   // Stop offering and let every outstanding result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_masks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_sched(logic [1:0] idx, logic [SCHED_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sched_reg[idx] = v;
   endtask

   // Load all four schedules with one kind of setting
   task automatic load_schedules(int kind);
      logic [SCHED_W-1:0] v;
      logic en;
      logic [4:0] hr;
      logic [5:0] mn;
      logic [DUR_W-1:0] dur;
      int z;
      wait_idle();
      for (z = 0; z < MASK_W; z++) begin
         en = ($urandom_range(0, 7) != 0);
         hr = ($urandom_range(0, 7) != 0) ? 5'($urandom_range(0, 23)) : 5'($urandom_range(24, 31));
         mn = ($urandom_range(0, 7) != 0) ? 6'($urandom_range(0, 59)) : 6'($urandom_range(60, 63));
         dur = ($urandom_range(0, 15) != 0) ? DUR_W'($urandom_range(0, 3))
                                             : DUR_W'($urandom_range(0, 1023));
         case (kind)
            SET_ALL_ZERO: v = '0;
            SET_ALL_ONES: v = '1;
            SET_RESET:    v = SCHED_RESET[z];
            SET_WIDE:     v = SCHED_W'($urandom());
            default:      v = pack_sched(en, hr, mn, dur);
         endcase
         write_sched(2'(ZONE1_SCHED + z), v);
      end
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   // One random item; ticks keep a wall time that mostly repeats, steps or hits a schedule
   task automatic random_item();
      int pick;
      int zs;
      func_type f;
      logic [1:0] zn;
      logic [7:0] mins;
      logic tv;
      logic [4:0] hr;
      logic [5:0] mn;
      pick = $urandom_range(0, 99);
      zn = 2'($urandom_range(0, 3));
      mins = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 2));
      tv = ($urandom_range(0, 7) != 0);
      if (pick < 72) f = FUNC_TICK;
      else if (pick < 86) f = FUNC_START;
      else if (pick < 97) f = FUNC_STOP;
      else f = FUNC_STOP_ALL;
      hr = 5'($urandom_range(0, 23));
      mn = 6'($urandom_range(0, 59));
      if (f == FUNC_TICK) begin
         pick = $urandom_range(0, 9);
         if (pick >= 4 && pick <= 6) begin
            zs = $urandom_range(0, ZONE_COUNT - 1);
            if (sched_reg[zs][SCHED_HR_HI:SCHED_HR_LO] <= HOUR_MAX)
               cur_hour = sched_reg[zs][SCHED_HR_HI:SCHED_HR_LO];
            if (sched_reg[zs][SCHED_MN_HI:SCHED_MN_LO] <= MINUTE_MAX)
               cur_min = sched_reg[zs][SCHED_MN_HI:SCHED_MN_LO];
         end else if (pick >= 7 && pick <= 8) begin
            cur_hour = hr;
            cur_min = mn;
         end else if (pick == 9) begin
            cur_min = (cur_min == MINUTE_MAX) ? 6'd0 : cur_min + 6'd1;
         end
         hr = cur_hour;
         mn = cur_min;
      end
      offer_item(f, zn, mins, hr, mn, tv, 1'b0, '0);
   endtask

   // Result receiver: random stall patterns plus one long hold-off on request
   initial begin
      int seg;
      int mode;
      int k;
      forever begin
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            holdoffs++;
            for (k = 0; k < HOLDOFF_CYC; k++) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         mode = $urandom_range(0, 3);
         seg = $urandom_range(4, 40);
         for (k = 0; k < seg; k++) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= (k % 4 == 3);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      zone_masks_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_masks.size() == 0) begin
            $error("unexpected result transfer: relay %h started %h stopped %h",
                   rsp_relay_mask, rsp_started_mask, rsp_stopped_mask);
            errors++;
         end else begin
            e = expected_masks.pop_front();
            rsp_checked++;
            if (rsp_relay_mask !== e.relay) begin
               $error("relay_mask: expected %h, got %h", e.relay, rsp_relay_mask);
               errors++;
            end
            if (rsp_started_mask !== e.started) begin
               $error("started_mask: expected %h, got %h", e.started, rsp_started_mask);
               errors++;
            end
            if (rsp_stopped_mask !== e.stopped) begin
               $error("stopped_mask: expected %h, got %h", e.stopped, rsp_stopped_mask);
               errors++;
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout at cycle %0d with %0d results outstanding",
                  cycle_count, expected_masks.size());
         $display("irrigation_zone_timer verification failed");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int z;
      int phase;
      int n;
      int burst;
      int gap;
      zone_on = '0;
      last_min = NO_MINUTE;
      for (z = 0; z < MASK_W; z++) begin
         secs_left[z] = '0;
         sched_reg[z] = SCHED_RESET[z];
      end

      // Reset schedules: manual commands, clamping, restart, idle stops
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd0,  6'd0,  1'b0, 1, 4'h0, 4'h0, 4'h0));
      plan.push_back(item_row(FUNC_STOP,     2'd0, 8'd0,   5'd0,  6'd0,  1'b0, 1, 4'h0, 4'h0, 4'h0));
      plan.push_back(item_row(FUNC_STOP_ALL, 2'd0, 8'd0,   5'd0,  6'd0,  1'b0, 1, 4'h0, 4'h0, 4'h0));
      plan.push_back(item_row(FUNC_START,    2'd0, 8'd0,   5'd0,  6'd0,  1'b1, 1, 4'h1, 4'h1, 4'h0));
      plan.push_back(item_row(FUNC_START,    2'd1, 8'd255, 5'd0,  6'd0,  1'b1, 1, 4'h3, 4'h2, 4'h0));
      plan.push_back(item_row(FUNC_START,    2'd2, 8'd120, 5'd0,  6'd0,  1'b1, 1, 4'h7, 4'h4, 4'h0));
      plan.push_back(item_row(FUNC_START,    2'd3, 8'd1,   5'd0,  6'd0,  1'b1, 1, 4'hF, 4'h8, 4'h0));
      plan.push_back(item_row(FUNC_START,    2'd0, 8'd200, 5'd0,  6'd0,  1'b1, 1, 4'hF, 4'h1, 4'h0));
      plan.push_back(item_row(FUNC_STOP,     2'd3, 8'd0,   5'd0,  6'd0,  1'b1, 1, 4'h7, 4'h0, 4'h8));
      plan.push_back(item_row(FUNC_STOP,     2'd3, 8'd0,   5'd0,  6'd0,  1'b1, 1, 4'h7, 4'h0, 4'h0));
      plan.push_back(item_row(FUNC_STOP_ALL, 2'd0, 8'd0,   5'd0,  6'd0,  1'b1, 1, 4'h0, 4'h0, 4'h7));
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd23, 6'd59, 1'b1, 1, 4'h0, 4'h0, 4'h0));
      // Zero-length run, one-minute run, out-of-range schedule, last minute of the day
      plan.push_back(csr_row(ZONE1_SCHED, pack_sched(1'b1, 5'd6, 6'd30, 10'd0)));
      plan.push_back(csr_row(ZONE2_SCHED, pack_sched(1'b1, 5'd6, 6'd30, 10'd1)));
      plan.push_back(csr_row(ZONE3_SCHED, '1));
      plan.push_back(csr_row(ZONE4_SCHED, pack_sched(1'b1, 5'd23, 6'd59, 10'd2)));
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd6,  6'd30, 1'b1, 1, 4'h3, 4'h3, 4'h0));
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd6,  6'd30, 1'b1, 1, 4'h2, 4'h0, 4'h1));
      // same minute, other hour: no rescan; then time not synchronised
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd7,  6'd30, 1'b1, 0, 4'h0, 4'h0, 4'h0));
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd23, 6'd59, 1'b0, 0, 4'h0, 4'h0, 4'h0));
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd23, 6'd59, 1'b1, 1, 4'hA, 4'h8, 4'h0));
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd6,  6'd30, 1'b1, 1, 4'hB, 4'h1, 4'h0));
      // expiry and scheduled restart on the same tick
      plan.push_back(csr_row(ZONE1_SCHED, pack_sched(1'b1, 5'd6, 6'd31, 10'd0)));
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd6,  6'd31, 1'b1, 1, 4'hB, 4'h1, 4'h1));
      plan.push_back(item_row(FUNC_TICK,     2'd0, 8'd0,   5'd0,  6'd0,  1'b0, 1, 4'hA, 4'h0, 4'h1));
      plan.push_back(item_row(FUNC_STOP_ALL, 2'd0, 8'd0,   5'd0,  6'd0,  1'b1, 1, 4'h0, 4'h0, 4'hA));

      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed plan
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (!csr_we) wait_idle();
            write_sched(plan[i].reg_idx, plan[i].value);
         end else begin
            csr_we <= 1'b0;
            offer_item(plan[i].func, plan[i].zone, plan[i].minutes, plan[i].hour,
                       plan[i].minute, plan[i].time_valid, plan[i].typed, plan[i].want);
            directed_items++;
         end
      end

      // Random phases, each under its own schedule setting
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         load_schedules((phase < SET_SHORT) ? phase : SET_SHORT);
         if (phase == 1) holdoff_req = 1'b1;
         burst = 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            random_item();
            burst--;
         end
      end

      wait_idle();
      $display("Covered %0d requests (%0d directed) under %0d schedule settings; %0d results checked",
               items_sent, directed_items, settings_loaded + 1, rsp_checked);
      $display("Zone starts %0d, zone stops %0d, long receiver hold-offs %0d",
               starts_seen, stops_seen, holdoffs);
      if (errors == 0) begin
         $display("irrigation_zone_timer verification clean");
      end else begin
         $display("irrigation_zone_timer verification failed");
      end
      $finish;
   end

endmodule
